>>> rtl/core/ttl_pkg.sv
`default_nettype none

package ttl_pkg;

    localparam int IN_W         = 18;
    localparam int OUT_W        = 19;
    localparam int A_W          = 19;
    localparam int REM_W        = 18;
    localparam int X_W          = 17;
    localparam int NUM_W        = 26;
    localparam int DEN_W        = 10;
    localparam int TAB_IDX_W    = 6;

    localparam int SEGMENTS_DEF = 18;
    localparam int ZERO_SHIFT   = 2280;
    localparam int TABLE_SPAN   = 11013;
    localparam int STEP_TEMP    = 500;
    localparam int SPAN_TEMP    = 9000;
    localparam int ORIGIN_TEMP  = 2000;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

    function automatic logic [DEN_W-1:0] step_width(input logic [TAB_IDX_W-1:0] idx);
        logic [DEN_W-1:0] w;
        case (idx)
            6'd0:    w = 10'd481;
            6'd1:    w = 10'd544;
            6'd2:    w = 10'd601;
            6'd3:    w = 10'd655;
            6'd4:    w = 10'd704;
            6'd5:    w = 10'd735;
            6'd6:    w = 10'd751;
            6'd7:    w = 10'd756;
            6'd8:    w = 10'd747;
            6'd9:    w = 10'd726;
            6'd10:   w = 10'd695;
            6'd11:   w = 10'd656;
            6'd12:   w = 10'd613;
            6'd13:   w = 10'd566;
            6'd14:   w = 10'd518;
            6'd15:   w = 10'd471;
            6'd16:   w = 10'd419;
            6'd17:   w = 10'd375;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ttl_div.sv
`default_nettype none

module ttl_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ttl_pkg::t_div_req i_req,
    output ttl_pkg::t_div_rsp      o_rsp
);

    localparam int NW    = ttl_pkg::NUM_W;
    localparam int DW    = ttl_pkg::DEN_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_num;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;

    logic [DW:0]      w_trial;
    logic             w_qbit;
    logic [DW-1:0]    w_rem_nx;

    always_comb begin
        w_trial  = {r_rem, r_num[NW-1]};
        w_qbit   = (w_trial >= {1'b0, r_den});
        w_rem_nx = w_qbit ? DW'(w_trial - {1'b0, r_den}) : w_trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_done <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], w_qbit};
            r_rem <= w_rem_nx;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = (r_den == '0) ? '0 : r_num;

endmodule

`default_nettype wire

>>> rtl/core/terminal_temperature_linearizer_top.sv
// Terminal temperature linearizer.
// Input channel: i_valid / o_stall carry one signed voltage count per item;
// an item is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one temperature in 0.01 degC per item.
// Each item walks the step table (one step per cycle), strips whole table
// spans (one per cycle) or, below the table, does neither, then runs a
// bit-serial division. One item is in work at a time; the next is accepted
// in the cycle after the result is loaded. The output register holds a
// result while the receiver stalls; a new item may be accepted and worked
// meanwhile, and waits at the end of its division until the output register
// is free.
// Reset empties the output register, returns the sequencer to idle and
// stops the divider; the working registers and the held temperature are
// not reset.
`default_nettype none

module terminal_temperature_linearizer_top #(
    parameter int SEGMENTS = ttl_pkg::SEGMENTS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic signed [ttl_pkg::IN_W-1:0]    i_voltage_count,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [ttl_pkg::OUT_W-1:0]        o_temperature
);

    localparam int LAST  = SEGMENTS - 1;
    localparam int IDX_W = $clog2(SEGMENTS);
    localparam int TW    = ttl_pkg::TAB_IDX_W;
    localparam int AW    = ttl_pkg::A_W;
    localparam int RW    = ttl_pkg::REM_W;
    localparam int XW    = ttl_pkg::X_W;
    localparam int NW    = ttl_pkg::NUM_W;
    localparam int DW    = ttl_pkg::DEN_W;
    localparam int OW    = ttl_pkg::OUT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DIV,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        M_BELOW,
        M_INSIDE,
        M_ABOVE
    } t_mode;

    t_state                  r_state;
    t_mode                   r_mode;
    logic [RW-1:0]           r_rem;
    logic [IDX_W-1:0]        r_idx;
    logic [OW-1:0]           r_base;
    logic                    r_neg;
    logic                    r_o_valid;
    logic [OW-1:0]           r_temp;

    logic signed [AW-1:0]    w_a;
    logic [DW-1:0]           w_cur;
    logic [DW-1:0]           w_first;
    logic [DW-1:0]           w_last;
    logic [XW-1:0]           w_x;
    logic [OW-1:0]           w_q;
    ttl_pkg::t_div_req       w_req;
    ttl_pkg::t_div_rsp       w_rsp;

    assign w_a     = AW'(ttl_pkg::ZERO_SHIFT) - AW'(i_voltage_count);
    assign w_cur   = ttl_pkg::step_width(TW'(r_idx));
    assign w_first = ttl_pkg::step_width('0);
    assign w_last  = ttl_pkg::step_width(TW'(LAST));
    assign w_x     = r_rem[XW-1:0];
    assign w_q     = w_rsp.quot[OW-1:0];

    always_comb begin
        w_req.start = 1'b0;
        w_req.den   = w_cur;
        w_req.num   = NW'(w_x) * NW'(ttl_pkg::STEP_TEMP);
        case (r_state)
            S_WALK: begin
                case (r_mode)
                    M_BELOW: begin
                        w_req.start = 1'b1;
                        w_req.den   = w_first;
                    end
                    M_ABOVE: begin
                        w_req.start = (r_rem < RW'(ttl_pkg::TABLE_SPAN));
                        w_req.den   = w_last;
                    end
                    M_INSIDE: begin
                        w_req.start = !((r_idx < IDX_W'(LAST)) && (r_rem > RW'(w_cur)));
                    end
                    default: begin
                        w_req.start = 1'b1;
                    end
                endcase
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    ttl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && (!r_o_valid || !i_stall)) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_idx  <= '0;
                        r_base <= '0;
                        r_neg  <= w_a[AW-1];
                        if (w_a[AW-1]) begin
                            r_mode <= M_BELOW;
                            r_rem  <= RW'(-w_a);
                        end else if (w_a[RW-1:0] > RW'(ttl_pkg::TABLE_SPAN)) begin
                            r_mode <= M_ABOVE;
                            r_rem  <= w_a[RW-1:0];
                        end else begin
                            r_mode <= M_INSIDE;
                            r_rem  <= w_a[RW-1:0];
                        end
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (w_req.start) begin
                        r_state <= S_DIV;
                    end else if (r_mode == M_ABOVE) begin
                        r_rem  <= r_rem - RW'(ttl_pkg::TABLE_SPAN);
                        r_base <= r_base + OW'(ttl_pkg::SPAN_TEMP);
                    end else begin
                        r_rem  <= r_rem - RW'(w_cur);
                        r_idx  <= r_idx + IDX_W'(1);
                        r_base <= r_base + OW'(ttl_pkg::STEP_TEMP);
                    end
                end
                S_DIV: begin
                    if (w_rsp.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_o_valid || !i_stall) begin
                        r_temp    <= r_base + (r_neg ? (~w_q + OW'(1)) : w_q)
                                     - OW'(ttl_pkg::ORIGIN_TEMP);
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_temperature = r_temp;

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy)
        else $error("division started while busy");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_DIV))
        else $error("division finished outside the divide state");

    a_walk_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_mode == M_INSIDE) |-> (r_rem <= RW'(ttl_pkg::TABLE_SPAN)))
        else $error("table walk remainder beyond span");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_FIN))
        else $error("result presented without finishing an item");

endmodule

`default_nettype wire
